FILE: sv/srdc_pkg.sv
// srdc_pkg: types and constants of the selection rectangle drag controller
// no dependencies

package srdc_pkg;

    localparam int unsigned HitHalf = 6;

    typedef enum logic [2:0] {
        EV_RESET  = 3'd0,
        EV_BEGIN  = 3'd1,
        EV_UPDATE = 3'd2,
        EV_END    = 3'd3,
        EV_CANCEL = 3'd4
    } t_event;

    typedef enum logic [1:0] {
        PH_UNSEL = 2'd0,
        PH_DRAG  = 2'd1,
        PH_SEL   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        OPN_NONE   = 2'd0,
        OPN_CREATE = 2'd1,
        OPN_MOVE   = 2'd2,
        OPN_RESIZE = 2'd3
    } t_oper;

    localparam logic [3:0] H_NONE = 4'd0;
    localparam logic [3:0] H_TL   = 4'd1;
    localparam logic [3:0] H_T    = 4'd2;
    localparam logic [3:0] H_TR   = 4'd3;
    localparam logic [3:0] H_R    = 4'd4;
    localparam logic [3:0] H_BR   = 4'd5;
    localparam logic [3:0] H_B    = 4'd6;
    localparam logic [3:0] H_BL   = 4'd7;
    localparam logic [3:0] H_L    = 4'd8;

    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_TOP    = 2'd1;
    localparam logic [1:0] REG_RIGHT  = 2'd2;
    localparam logic [1:0] REG_BOTTOM = 2'd3;

    // handle direction: -1 low side, 0 none, +1 high side
    function automatic logic [1:0] hdir_neg_pos(input logic [3:0] h);
        // bit0 negative, bit1 positive
        hdir_neg_pos = {(h == H_TR || h == H_R || h == H_BR),
                        (h == H_TL || h == H_BL || h == H_L)};
    endfunction

    function automatic logic [1:0] vdir_neg_pos(input logic [3:0] h);
        vdir_neg_pos = {(h == H_BR || h == H_B || h == H_BL),
                        (h == H_TL || h == H_T || h == H_TR)};
    endfunction

    function automatic logic [3:0] handle_from(input logic [1:0] hd, input logic [1:0] vd);
        logic [3:0] r;
        r = H_NONE;
        if (vd[0]) begin
            r = hd[0] ? H_TL : (hd[1] ? H_TR : H_T);
        end else if (vd[1]) begin
            r = hd[1] ? H_BR : (hd[0] ? H_BL : H_B);
        end else if (hd[1]) begin
            r = H_R;
        end else if (hd[0]) begin
            r = H_L;
        end
        handle_from = r;
    endfunction

endpackage

FILE: sv/srdc_if.sv
// srdc_if: valid/ready channel interfaces for events, results and configuration
// depends on no package

interface srdc_evt_if #(parameter int CW = 16);
    logic              valid;
    logic              ready;
    logic [2:0]        op;
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    modport source (output valid, op, pos_x, pos_y, input ready);
    modport sink   (input valid, op, pos_x, pos_y, output ready);
endinterface

interface srdc_res_if #(parameter int CW = 16);
    logic              valid;
    logic              ready;
    logic              ok;
    logic [1:0]        phase;
    logic [1:0]        operation;
    logic [3:0]        handle;
    logic signed [CW-1:0] sel_left;
    logic signed [CW-1:0] sel_top;
    logic signed [CW-1:0] sel_right;
    logic signed [CW-1:0] sel_bottom;
    logic              has_selection;
    logic              show_handles;
    modport source (output valid, ok, phase, operation, handle, sel_left, sel_top,
                    sel_right, sel_bottom, has_selection, show_handles, input ready);
    modport sink   (input valid, ok, phase, operation, handle, sel_left, sel_top,
                    sel_right, sel_bottom, has_selection, show_handles, output ready);
endinterface

interface srdc_cfg_if #(parameter int CW = 16);
    logic          valid;
    logic          ready;
    logic [1:0]    index;
    logic [CW-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/srdc_hit.sv
// srdc_hit: eight-handle hit test around the current selection
// depends on srdc_pkg

module srdc_hit import srdc_pkg::*; #(
    parameter int CW = 16
) (
    input  logic signed [CW-1:0] i_l,
    input  logic signed [CW-1:0] i_t,
    input  logic signed [CW-1:0] i_r,
    input  logic signed [CW-1:0] i_b,
    input  logic signed [CW-1:0] i_px,
    input  logic signed [CW-1:0] i_py,
    output logic [3:0]           o_handle
);
    localparam int XW = CW + 2;
    localparam logic signed [XW-1:0] HH = XW'(HitHalf);

    logic signed [XW-1:0] hc, vc;
    logic signed [XW-1:0] cx [8];
    logic signed [XW-1:0] cy [8];
    logic [7:0] in_win;
    logic [7:0] dsq [8];

    // centers, truncating halving toward zero like integer division
    always_comb begin
        logic signed [XW-1:0] wd, ht;
        wd = XW'(i_r) - XW'(i_l);
        ht = XW'(i_b) - XW'(i_t);
        hc = XW'(i_l) + ((wd + XW'(wd[XW-1])) >>> 1);
        vc = XW'(i_t) + ((ht + XW'(ht[XW-1])) >>> 1);
        cx[0] = XW'(i_l); cy[0] = XW'(i_t);
        cx[1] = hc;       cy[1] = XW'(i_t);
        cx[2] = XW'(i_r); cy[2] = XW'(i_t);
        cx[3] = XW'(i_r); cy[3] = vc;
        cx[4] = XW'(i_r); cy[4] = XW'(i_b);
        cx[5] = hc;       cy[5] = XW'(i_b);
        cx[6] = XW'(i_l); cy[6] = XW'(i_b);
        cx[7] = XW'(i_l); cy[7] = vc;
    end

    // per handle window test and squared distance (small values only)
    for (genvar g = 0; g < 8; g++) begin : g_h
        logic signed [XW-1:0] dx, dy;
        logic signed [4:0] sx, sy;
        assign dx = XW'(i_px) - cx[g];
        assign dy = XW'(i_py) - cy[g];
        assign in_win[g] = (dx >= -HH) && (dx < HH) &&
                           (dy >= -HH) && (dy < HH);
        assign sx = dx[4:0];
        assign sy = dy[4:0];
        assign dsq[g] = 8'(sx * sx) + 8'(sy * sy);
    end

    // nearest handle, corner replaces an edge handle on a tie
    always_comb begin
        logic [7:0] best;
        logic found, ncorner, corner;
        logic [3:0] nearest;
        best = '1; found = 1'b0; nearest = H_NONE; ncorner = 1'b0;
        for (int i = 0; i < 8; i++) begin
            corner = (i % 2) == 0;
            if (in_win[i] && (!found || dsq[i] < best ||
                              (dsq[i] == best && corner && !ncorner))) begin
                best = dsq[i];
                found = 1'b1;
                nearest = 4'(i + 1);
                ncorner = corner;
            end
        end
        o_handle = nearest;
    end
endmodule

FILE: sv/selection_rect_drag_controller.sv
// selection_rect_drag_controller: pointer driven rectangle selection controller
// the result is registered the cycle after an event transfer; one event per cycle while not stalled
// the state update is one pass of combinational logic into the state registers
// and the result register; a stalled result blocks the input only when full
// reset (i_rst_n low, synchronous) clears bounds, selection and drag state
// depends on srdc_pkg, srdc_if, srdc_hit

module selection_rect_drag_controller import srdc_pkg::*; #(
    parameter int COORD_WIDTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    srdc_evt_if.sink   evt,
    srdc_res_if.source res,
    srdc_cfg_if.sink   cfg
);
    localparam int CW = COORD_WIDTH;
    localparam int XW = CW + 2;
    typedef logic signed [CW-1:0] t_c;
    typedef logic signed [XW-1:0] t_x;

    t_c r_bl, r_bt, r_br, r_bb;
    t_c r_sel [4];
    t_c r_st  [4];
    t_c r_ox, r_oy, r_fx, r_fy;
    logic [1:0] r_axes;
    t_phase r_phase;
    t_oper  r_oper;
    logic [3:0] r_handle;

    t_c n_sel [4];
    t_c n_st  [4];
    t_c n_ox, n_oy, n_fx, n_fy;
    logic [1:0] n_axes;
    t_phase n_phase;
    t_oper  n_oper;
    logic [3:0] n_handle;
    logic n_ok;

    logic r_valid, r_ok;
    logic evt_xfer;
    logic [3:0] hit;

    assign cfg.ready = 1'b1;
    assign evt.ready = !r_valid || res.ready;
    assign evt_xfer  = evt.valid && evt.ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bl <= '0; r_bt <= '0; r_br <= '0; r_bb <= '0;
        end else if (cfg.valid) begin
            case (cfg.index)
                REG_LEFT:   r_bl <= cfg.data;
                REG_TOP:    r_bt <= cfg.data;
                REG_RIGHT:  r_br <= cfg.data;
                REG_BOTTOM: r_bb <= cfg.data;
                default:    r_bl <= r_bl;
            endcase
        end
    end

    srdc_hit #(.CW(CW)) u_hit (
        .i_l(r_sel[0]), .i_t(r_sel[1]), .i_r(r_sel[2]), .i_b(r_sel[3]),
        .i_px(evt.pos_x), .i_py(evt.pos_y), .o_handle(hit)
    );

    // next state for one event
    always_comb begin
        t_x px, py, x, y, ox, oy, bl, bt, br, bb, fx, fy, w, h, l, t;
        logic sel_empty, bnd_empty, in_rect, changed;
        logic [1:0] hd, vd, ehd, evd;
        t_c u_sel [4];
        logic [3:0] u_handle;

        px = t_x'(evt.pos_x); py = t_x'(evt.pos_y);
        bl = t_x'(r_bl); bt = t_x'(r_bt); br = t_x'(r_br); bb = t_x'(r_bb);
        x = (px < bl) ? bl : ((px > br) ? br : px);
        y = (py < bt) ? bt : ((py > bb) ? bb : py);
        ox = t_x'(r_ox); oy = t_x'(r_oy);
        fx = t_x'(r_fx); fy = t_x'(r_fy);
        sel_empty = (r_sel[2] <= r_sel[0]) || (r_sel[3] <= r_sel[1]);
        bnd_empty = (r_br <= r_bl) || (r_bb <= r_bt);
        in_rect = !sel_empty && evt.pos_x >= r_sel[0] && evt.pos_x < r_sel[2] &&
                  evt.pos_y >= r_sel[1] && evt.pos_y < r_sel[3];
        hd = hdir_neg_pos(hit);
        vd = vdir_neg_pos(hit);
        ehd = hdir_neg_pos(r_handle);
        evd = vdir_neg_pos(r_handle);

        n_sel = r_sel; n_st = r_st;
        n_ox = r_ox; n_oy = r_oy; n_fx = r_fx; n_fy = r_fy;
        n_axes = r_axes; n_phase = r_phase; n_oper = r_oper; n_handle = r_handle;
        n_ok = 1'b0;

        // update step, shared by update and end
        u_sel = r_sel; u_handle = r_handle;
        w = t_x'(r_st[2]) - t_x'(r_st[0]);
        h = t_x'(r_st[3]) - t_x'(r_st[1]);
        l = t_x'(r_st[0]) + x - ox;
        t = t_x'(r_st[1]) + y - oy;
        l = (l < bl) ? bl : ((l > br - w) ? br - w : l);
        t = (t < bt) ? bt : ((t > bb - h) ? bb - h : t);
        case (r_oper)
            OPN_CREATE: begin
                if (x > ox && x == br - 1) x = br;
                else if (x < ox && ox == br - 1) ox = br;
                if (y > oy && y == bb - 1) y = bb;
                else if (y < oy && oy == bb - 1) oy = bb;
                u_sel[0] = t_c'((x < ox) ? x : ox);
                u_sel[1] = t_c'((y < oy) ? y : oy);
                u_sel[2] = t_c'((x > ox) ? x : ox);
                u_sel[3] = t_c'((y > oy) ? y : oy);
            end
            OPN_MOVE: begin
                u_sel[0] = t_c'(l); u_sel[1] = t_c'(t);
                u_sel[2] = t_c'(l + w); u_sel[3] = t_c'(t + h);
            end
            OPN_RESIZE: begin
                u_sel = r_st;
                if (r_axes[0]) begin
                    if (x > fx && x == br - 1) x = br;
                    u_sel[0] = t_c'((x < fx) ? x : fx);
                    u_sel[2] = t_c'((x > fx) ? x : fx);
                    if (x < fx) ehd = 2'b01;
                    else if (x > fx) ehd = 2'b10;
                end
                if (r_axes[1]) begin
                    if (y > fy && y == bb - 1) y = bb;
                    u_sel[1] = t_c'((y < fy) ? y : fy);
                    u_sel[3] = t_c'((y > fy) ? y : fy);
                    if (y < fy) evd = 2'b01;
                    else if (y > fy) evd = 2'b10;
                end
                u_handle = handle_from(ehd, evd);
            end
            default: begin
                u_sel = r_sel;
            end
        endcase
        changed = (u_sel[0] != r_sel[0]) || (u_sel[1] != r_sel[1]) ||
                  (u_sel[2] != r_sel[2]) || (u_sel[3] != r_sel[3]);

        case (evt.op)
            EV_RESET: begin
                n_ok = 1'b1;
                n_sel = '{default: '0}; n_st = '{default: '0};
                n_ox = '0; n_oy = '0; n_fx = '0; n_fy = '0; n_axes = '0;
                n_phase = PH_UNSEL; n_oper = OPN_NONE; n_handle = H_NONE;
            end
            EV_BEGIN: begin
                if (!bnd_empty && r_phase != PH_DRAG) begin
                    n_st = r_sel; n_handle = H_NONE; n_axes = '0;
                    n_ok = 1'b1; n_phase = PH_DRAG;
                    if (r_phase == PH_UNSEL) begin
                        n_ox = t_c'(x); n_oy = t_c'(y);
                        n_sel[0] = t_c'(x); n_sel[1] = t_c'(y);
                        n_sel[2] = t_c'(x); n_sel[3] = t_c'(y);
                        n_oper = OPN_CREATE;
                    end else if (r_phase == PH_SEL && !sel_empty && hit != H_NONE) begin
                        n_ox = evt.pos_x; n_oy = evt.pos_y;
                        n_handle = hit; n_oper = OPN_RESIZE;
                        n_axes = {|vd, |hd};
                        if (hd[0]) n_fx = r_sel[2];
                        else if (hd[1]) n_fx = r_sel[0];
                        if (vd[0]) n_fy = r_sel[3];
                        else if (vd[1]) n_fy = r_sel[1];
                    end else if (in_rect) begin
                        n_ox = evt.pos_x; n_oy = evt.pos_y;
                        n_oper = OPN_MOVE;
                    end else begin
                        n_st = '{default: '0};
                        n_ok = 1'b0; n_phase = r_phase;
                    end
                end
            end
            EV_UPDATE: begin
                if (r_phase == PH_DRAG && r_oper != OPN_NONE) begin
                    n_sel = u_sel; n_handle = u_handle; n_ok = changed;
                end
            end
            EV_END, EV_CANCEL: begin
                if (r_phase == PH_DRAG) begin
                    n_ok = 1'b1;
                    if (evt.op == EV_END) begin
                        n_sel = u_sel;
                    end
                    if (evt.op == EV_CANCEL || u_sel[2] <= u_sel[0] ||
                        u_sel[3] <= u_sel[1]) begin
                        if (r_oper == OPN_CREATE) begin
                            n_sel = '{default: '0};
                            n_ox = '0; n_oy = '0; n_fx = '0; n_fy = '0;
                            n_phase = PH_UNSEL;
                        end else begin
                            n_sel = r_st; n_phase = PH_SEL;
                        end
                    end else begin
                        n_phase = PH_SEL;
                    end
                    n_st = '{default: '0}; n_oper = OPN_NONE;
                    n_handle = H_NONE; n_axes = '0;
                end
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    // state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= '{default: '0}; r_st <= '{default: '0};
            r_ox <= '0; r_oy <= '0; r_fx <= '0; r_fy <= '0; r_axes <= '0;
            r_phase <= PH_UNSEL; r_oper <= OPN_NONE; r_handle <= H_NONE;
            r_valid <= 1'b0; r_ok <= 1'b0;
        end else begin
            if (evt_xfer) begin
                r_sel <= n_sel; r_st <= n_st;
                r_ox <= n_ox; r_oy <= n_oy; r_fx <= n_fx; r_fy <= n_fy;
                r_axes <= n_axes; r_phase <= n_phase; r_oper <= n_oper;
                r_handle <= n_handle; r_ok <= n_ok;
                r_valid <= 1'b1;
            end else if (res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // result view of the state after the last event
    assign res.valid = r_valid;
    assign res.ok = r_ok;
    assign res.phase = r_phase;
    assign res.operation = r_oper;
    assign res.handle = r_handle;
    assign res.sel_left = r_sel[0];
    assign res.sel_top = r_sel[1];
    assign res.sel_right = r_sel[2];
    assign res.sel_bottom = r_sel[3];
    assign res.has_selection = (r_sel[2] > r_sel[0]) && (r_sel[3] > r_sel[1]);
    assign res.show_handles = res.has_selection &&
        (r_phase == PH_SEL || r_oper == OPN_MOVE || r_oper == OPN_RESIZE);

`ifndef NO_ASSERTIONS
    // an unselected controller has no operation in progress
    a_unsel_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_UNSEL |-> r_oper == OPN_NONE && r_handle == H_NONE)
        else $error("operation active while unselected");
    // a resize always carries a handle
    a_resize_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oper == OPN_RESIZE |-> r_handle != H_NONE)
        else $error("resize without handle");
    // a pending result is held while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !res.ready |=> r_valid && $stable(r_sel[0]) && $stable(r_phase))
        else $error("result changed while stalled");
`endif
endmodule
